/* src/expanded_memory_handle_manager_macros.svh */
// Assertion macros shared by the expanded memory handle manager RTL.
`ifndef EXPANDED_MEMORY_HANDLE_MANAGER_MACROS_SVH
`define EXPANDED_MEMORY_HANDLE_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
`define EMHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define EMHM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define EMHM_ASSERT(lbl, prop, msg)
`define EMHM_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* src/emhm_pkg.sv */
// Package with the widths, codes and types of the expanded memory handle manager.
`timescale 1ns / 1ps
package emhm_pkg;

  localparam int unsigned CMD_W   = 8;
  localparam int unsigned SUB_W   = 8;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned NAME_W  = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned AL_W    = 8;
  localparam int unsigned PAGE_W  = 11;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_HANDLE  = 3'd1,
    ST_NO_HANDLES  = 3'd2,
    ST_NO_PAGES    = 3'd3,
    ST_UNSUPPORTED = 3'd4,
    ST_BAD_WINDOW  = 3'd5
  } status_e;

  localparam logic [CMD_W-1:0] CMD_STATUS  = 8'h40;
  localparam logic [CMD_W-1:0] CMD_FRAME   = 8'h41;
  localparam logic [CMD_W-1:0] CMD_PAGES   = 8'h42;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 8'h43;
  localparam logic [CMD_W-1:0] CMD_MAP     = 8'h44;
  localparam logic [CMD_W-1:0] CMD_FREE    = 8'h45;
  localparam logic [CMD_W-1:0] CMD_VERSION = 8'h46;
  localparam logic [CMD_W-1:0] CMD_HCOUNT  = 8'h4B;
  localparam logic [CMD_W-1:0] CMD_NAME    = 8'h53;

  localparam logic [SUB_W-1:0] NAME_GET = 8'd0;
  localparam logic [SUB_W-1:0] NAME_SET = 8'd1;

  localparam logic [WORD_W-1:0] UNMAP_PAGE   = 16'hFFFF;
  localparam logic [WORD_W-1:0] FRAME_RESET  = 16'hD000;
  localparam logic [AL_W-1:0]   VERSION_BYTE = 8'h40;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_FREE = 6'b001000,
    S_NAME = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

endpackage

/* src/emhm_req_if.sv */
// Request channel interface of the expanded memory handle manager.
`timescale 1ns / 1ps
interface emhm_req_if;
  import emhm_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SUB_W-1:0]    subfunction;
  logic [HANDLE_W-1:0] handle_in;
  logic [WORD_W-1:0]   count_or_page;
  logic [NAME_W-1:0]   name_in;

  modport source (
    output valid, command, subfunction, handle_in, count_or_page, name_in,
    input  ready
  );
  modport sink (
    input  valid, command, subfunction, handle_in, count_or_page, name_in,
    output ready
  );
endinterface

/* src/emhm_rsp_if.sv */
// Response channel interface of the expanded memory handle manager.
`timescale 1ns / 1ps
interface emhm_rsp_if;
  import emhm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   out_bx;
  logic [WORD_W-1:0]   out_dx;
  logic [AL_W-1:0]     out_al;
  logic [NAME_W-1:0]   name_out;

  modport source (
    output valid, status, out_bx, out_dx, out_al, name_out,
    input  ready
  );
  modport sink (
    input  valid, status, out_bx, out_dx, out_al, name_out,
    output ready
  );
endinterface

/* src/expanded_memory_handle_manager.sv */
// Top level of the expanded memory handle manager: request sequencer and handle table.
`timescale 1ns / 1ps
`include "expanded_memory_handle_manager_macros.svh"
// The block answers one expanded memory request per item. Requests arrive on the
// req channel and each produces exactly one item on the rsp channel, both with
// valid/ready handshakes. The user must write the frame segment register through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
// A small sequencer takes one request at a time: req.ready is high only while it
// is idle. Simple queries go from acceptance to rsp.valid through the result register
// (filled by decode) and then the output register. Free and get name add a
// registered read of the page count or name memory. Allocate walks the allocated
// flags one handle per cycle starting at handle 1. The sequencer returns to idle,
// raising req.ready, in the same cycle that rsp.valid rises.
// The output register decouples the two sides: a new request is accepted while a
// finished response still waits, and its result is held in the sequencer until
// the output register is free, so a stalled receiver only delays the next result.
// Reset clears all handles, name valid flags, the page count and the window
// mappings at once; there is no clearing pass and the block is ready right after
// reset. The frame segment returns to D000h.
module expanded_memory_handle_manager #(
  parameter int unsigned TOTAL_PAGES  = 1024,
  parameter int unsigned HANDLE_COUNT = 256,
  parameter int unsigned WINDOW_COUNT = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [emhm_pkg::WORD_W-1:0] cfg_wdata_i,
  emhm_req_if.sink                   req,
  emhm_rsp_if.source                 rsp
);
  import emhm_pkg::*;

  localparam int unsigned HW = $clog2(HANDLE_COUNT);
  localparam int unsigned WW = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
  localparam logic [HANDLE_W-1:0] HC16 = HANDLE_W'(HANDLE_COUNT);
  localparam logic [SUB_W-1:0]    WC8  = SUB_W'(WINDOW_COUNT);
  localparam logic [PAGE_W-1:0]   TP11 = PAGE_W'(TOTAL_PAGES);
  localparam logic [HW-1:0]       LAST_HANDLE = HW'(HANDLE_COUNT - 1);

  // Sequencer and latched request.
  state_e              state_q, state_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [SUB_W-1:0]    sub_q;
  logic [HANDLE_W-1:0] h_q;
  logic [WORD_W-1:0]   cp_q;
  logic [NAME_W-1:0]   nm_q;

  // Handle table and global state.
  logic [HANDLE_COUNT-1:0] alloc_q, alloc_d;
  logic [HANDLE_COUNT-1:0] nvalid_q, nvalid_d;
  logic [PAGE_W-1:0]       pages_q, pages_d;
  logic [HW-1:0]           win_h_q [WINDOW_COUNT];
  logic [HW-1:0]           win_h_d [WINDOW_COUNT];
  logic [WORD_W-1:0]       frame_q;
  logic [HW-1:0]           scan_q, scan_d;

  // Page count and name memories, one entry per handle.
  logic [PAGE_W-1:0] pc_mem [HANDLE_COUNT];
  logic [NAME_W-1:0] name_mem [HANDLE_COUNT];
  logic [PAGE_W-1:0] pc_rd_q;
  logic [NAME_W-1:0] name_rd_q;
  logic              pc_we, pc_re, name_we, name_re;
  logic [HW-1:0]     pc_waddr;

  // Pending result and output register.
  status_e           res_st_q, res_st_d;
  logic [WORD_W-1:0] res_bx_q, res_bx_d;
  logic [WORD_W-1:0] res_dx_q, res_dx_d;
  logic [AL_W-1:0]   res_al_q, res_al_d;
  logic [NAME_W-1:0] res_nm_q, res_nm_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_st_q;
  logic [WORD_W-1:0]   rsp_bx_q, rsp_dx_q;
  logic [AL_W-1:0]     rsp_al_q;
  logic [NAME_W-1:0]   rsp_nm_q;
  logic                rsp_load;

  logic              req_fire;
  logic [HW-1:0]     h_idx;
  logic [WW-1:0]     w_idx;
  logic              h_in_range;
  logic [PAGE_W-1:0] pages_free;

  assign req_fire   = req.valid && req.ready;
  assign req.ready  = (state_q == S_IDLE);
  assign h_idx      = h_q[HW-1:0];
  assign w_idx      = sub_q[WW-1:0];
  assign h_in_range = (h_q < HC16);
  // Pages in use never exceed the total, so this difference does not wrap.
  assign pages_free = TP11 - pages_q;

  always_comb begin
    state_d     = state_q;
    alloc_d     = alloc_q;
    nvalid_d    = nvalid_q;
    pages_d     = pages_q;
    win_h_d     = win_h_q;
    scan_d      = scan_q;
    res_st_d    = res_st_q;
    res_bx_d    = res_bx_q;
    res_dx_d    = res_dx_q;
    res_al_d    = res_al_q;
    res_nm_d    = res_nm_q;
    pc_we       = 1'b0;
    pc_re       = 1'b0;
    pc_waddr    = scan_q;
    name_we     = 1'b0;
    name_re     = 1'b0;
    rsp_load    = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp.ready;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // Every field not set on a success path stays zero.
        res_st_d = ST_OK;
        res_bx_d = '0;
        res_dx_d = '0;
        res_al_d = '0;
        res_nm_d = '0;
        state_d  = S_EMIT;
        unique case (cmd_q)
          CMD_STATUS: begin
          end
          CMD_FRAME: begin
            res_bx_d = frame_q;
          end
          CMD_PAGES: begin
            res_bx_d = WORD_W'(pages_free);
            res_dx_d = WORD_W'(TP11);
          end
          CMD_ALLOC: begin
            scan_d  = HW'(1);
            state_d = S_SCAN;
          end
          CMD_MAP: begin
            if (sub_q >= WC8) begin
              res_st_d = ST_BAD_WINDOW;
            end else if ((h_q == '0) || (cp_q == UNMAP_PAGE)) begin
              win_h_d[w_idx] = '0;
            end else if (!h_in_range || !alloc_q[h_idx]) begin
              res_st_d = ST_BAD_HANDLE;
            end else begin
              win_h_d[w_idx] = h_idx;
              res_bx_d       = cp_q;
              res_dx_d       = h_q;
            end
          end
          CMD_FREE: begin
            if (!h_in_range) begin
              res_st_d = ST_BAD_HANDLE;
            end else if (alloc_q[h_idx]) begin
              pc_re   = 1'b1;
              state_d = S_FREE;
            end
          end
          CMD_VERSION: begin
            res_al_d = VERSION_BYTE;
          end
          CMD_HCOUNT: begin
            res_bx_d = HC16;
          end
          CMD_NAME: begin
            if (!h_in_range) begin
              res_st_d = ST_BAD_HANDLE;
            end else if (sub_q == NAME_GET) begin
              name_re = 1'b1;
              state_d = S_NAME;
            end else if (sub_q == NAME_SET) begin
              name_we         = 1'b1;
              nvalid_d[h_idx] = 1'b1;
            end else begin
              res_st_d = ST_UNSUPPORTED;
            end
          end
          default: begin
            res_st_d = ST_UNSUPPORTED;
          end
        endcase
      end
      S_SCAN: begin
        // One allocated flag per cycle; the first free handle ends the walk.
        if (!alloc_q[scan_q]) begin
          state_d = S_EMIT;
          if (cp_q > WORD_W'(pages_free)) begin
            res_st_d = ST_NO_PAGES;
          end else begin
            alloc_d[scan_q] = 1'b1;
            pc_we           = 1'b1;
            pages_d         = pages_q + cp_q[PAGE_W-1:0];
            res_dx_d        = WORD_W'(scan_q);
          end
        end else if (scan_q == LAST_HANDLE) begin
          res_st_d = ST_NO_HANDLES;
          state_d  = S_EMIT;
        end else begin
          scan_d = scan_q + HW'(1);
        end
      end
      S_FREE: begin
        pages_d        = pages_q - pc_rd_q;
        alloc_d[h_idx] = 1'b0;
        for (int w = 0; w < WINDOW_COUNT; w++) begin
          if (win_h_q[w] == h_idx) begin
            win_h_d[w] = '0;
          end
        end
        state_d = S_EMIT;
      end
      S_NAME: begin
        // A name that was never written reads as zero.
        res_nm_d = nvalid_q[h_idx] ? name_rd_q : '0;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!rsp_valid_q || rsp.ready) begin
          rsp_load    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alloc_q     <= '0;
      nvalid_q    <= '0;
      pages_q     <= '0;
      frame_q     <= FRAME_RESET;
      rsp_valid_q <= 1'b0;
      for (int w = 0; w < WINDOW_COUNT; w++) begin
        win_h_q[w] <= '0;
      end
    end else begin
      state_q     <= state_d;
      alloc_q     <= alloc_d;
      nvalid_q    <= nvalid_d;
      pages_q     <= pages_d;
      win_h_q     <= win_h_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        frame_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= req.command;
      sub_q <= req.subfunction;
      h_q   <= req.handle_in;
      cp_q  <= req.count_or_page;
      nm_q  <= req.name_in;
    end
    scan_q   <= scan_d;
    res_st_q <= res_st_d;
    res_bx_q <= res_bx_d;
    res_dx_q <= res_dx_d;
    res_al_q <= res_al_d;
    res_nm_q <= res_nm_d;
    if (rsp_load) begin
      rsp_st_q <= res_st_q;
      rsp_bx_q <= res_bx_q;
      rsp_dx_q <= res_dx_q;
      rsp_al_q <= res_al_q;
      rsp_nm_q <= res_nm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pc_we) begin
      pc_mem[pc_waddr] <= cp_q[PAGE_W-1:0];
    end
    if (pc_re) begin
      pc_rd_q <= pc_mem[h_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[h_idx] <= nm_q;
    end
    if (name_re) begin
      name_rd_q <= name_mem[h_idx];
    end
  end

  assign rsp.valid    = rsp_valid_q;
  assign rsp.status   = rsp_st_q;
  assign rsp.out_bx   = rsp_bx_q;
  assign rsp.out_dx   = rsp_dx_q;
  assign rsp.out_al   = rsp_al_q;
  assign rsp.name_out = rsp_nm_q;

  `EMHM_ASSERT_NEVER(a_pages_bound, pages_q > TP11, "pages in use exceed total pages")
  `EMHM_ASSERT_NEVER(a_handle0_free, alloc_q[0], "reserved handle zero became allocated")
  `EMHM_ASSERT(a_busy_after_accept, req_fire |=> !req.ready, "request taken while busy")

  for (genvar g = 0; g < WINDOW_COUNT; g++) begin : g_win_chk
    `EMHM_ASSERT(a_win_alloc, (win_h_q[g] != '0) |-> alloc_q[win_h_q[g]], "window maps freed handle")
  end

endmodule
